// ===== hw/rtl/mh3_pkg.sv =====
// mh3_pkg: constants, types and helpers shared by the MurmurHash3 x64_128 unit.
// No dependencies; compiled before every other file of the block.
package mh3_pkg;

  // Lane mixing multipliers
  localparam logic [63:0] LANE_C1  = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] LANE_C2  = 64'h4cf5_ad43_2745_937f;
  // Hash word offsets after the times-five step
  localparam logic [63:0] MIX_ADD1 = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] MIX_ADD2 = 64'h0000_0000_3849_5ab5;
  // Finalizer multipliers
  localparam logic [63:0] FMIX_F1  = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FMIX_F2  = 64'hc4ce_b9fe_1a85_ec53;

  // Bytes in one message block and in one lane
  localparam logic [4:0] BLOCK_BYTES = 5'd16;
  localparam logic [4:0] LANE_BYTES  = 5'd8;

  // Request into a 64x64 low-half multiplier; each lane and finalizer has its own
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // Mask that keeps the low n bytes of a lane, n in 0..8
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/mh3_mul64.sv =====
// mh3_mul64: low 64 bits of a 64x64 product, built from one 32x32 multiplier
// in the steps lo*lo, lo*hi, hi*lo. Depends on mh3_pkg.
module mh3_mul64 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mh3_pkg::mul_req_t req_i,
  output logic              done_o,
  output logic [63:0]       result_o
);
  import mh3_pkg::*;

  localparam logic [1:0] STEP_LO_LO = 2'd0;
  localparam logic [1:0] STEP_LO_HI = 2'd1;
  localparam logic [1:0] STEP_HI_LO = 2'd2;

  logic        busy_q;
  logic        done_q;
  logic [1:0]  step_q;
  logic [63:0] a_q, b_q, acc_q;
  logic [31:0] opx, opy;
  logic [63:0] prod;

  // Operand select for the partial product of this step
  always_comb begin
    case (step_q)
      STEP_LO_LO: begin
        opx = a_q[31:0];
        opy = b_q[31:0];
      end
      STEP_LO_HI: begin
        opx = a_q[31:0];
        opy = b_q[63:32];
      end
      STEP_HI_LO: begin
        opx = a_q[63:32];
        opy = b_q[31:0];
      end
      default: begin
        opx = a_q[31:0];
        opy = b_q[31:0];
      end
    endcase
    prod = {32'd0, opx} * {32'd0, opy};
  end

  // Step sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= STEP_LO_LO;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= STEP_LO_LO;
      end else if (busy_q) begin
        case (step_q)
          STEP_LO_LO: step_q <= STEP_LO_HI;
          STEP_LO_HI: step_q <= STEP_HI_LO;
          STEP_HI_LO: begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
          default: busy_q <= 1'b0;
        endcase
      end
    end
  end

  // Operands and accumulator; cross terms only touch the upper word
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end else if (busy_q) begin
      if (step_q == STEP_LO_LO) begin
        acc_q <= prod;
      end else begin
        acc_q[63:32] <= acc_q[63:32] + prod[31:0];
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

// ===== hw/rtl/mh3_lane.sv =====
// mh3_lane: one key lane, k * Ca, rotate, * Cb, on its own mh3_mul64.
// Depends on mh3_pkg and mh3_mul64; lane_two_i picks the second lane's constants.
module mh3_lane (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        lane_two_i,
  input  logic [63:0] key_i,
  output logic        done_o,
  output logic [63:0] result_o
);
  import mh3_pkg::*;

  mul_req_t    mul_req;
  logic        mul_done;
  logic [63:0] mul_res;
  logic [63:0] rot;
  logic        phase_q;
  logic        done_q;
  logic [63:0] result_q;

  // Second lane rotates by 33, first by 31
  assign rot = lane_two_i ? {mul_res[30:0], mul_res[63:31]}
                          : {mul_res[32:0], mul_res[63:33]};

  // First multiply on start, second as soon as the first one finishes
  always_comb begin
    mul_req.start = start_i | (mul_done & ~phase_q);
    if (start_i) begin
      mul_req.a = key_i;
      mul_req.b = lane_two_i ? LANE_C2 : LANE_C1;
    end else begin
      mul_req.a = rot;
      mul_req.b = lane_two_i ? LANE_C1 : LANE_C2;
    end
  end

  mh3_mul64 u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mul_req),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= mul_done & phase_q;
      if (start_i) begin
        phase_q <= 1'b0;
      end else if (mul_done && !phase_q) begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_done && phase_q) begin
      result_q <= mul_res;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== hw/rtl/mh3_fmix.sv =====
// mh3_fmix: 64-bit finalizer (xor-shift, multiply, xor-shift, multiply, xor-shift).
// Depends on mh3_pkg and mh3_mul64.
module mh3_fmix (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [63:0] result_o
);
  import mh3_pkg::*;

  mul_req_t    mul_req;
  logic        mul_done;
  logic [63:0] mul_res;
  logic [63:0] res_xs;
  logic        phase_q;
  logic        done_q;
  logic [63:0] result_q;

  assign res_xs = mul_res ^ (mul_res >> 33);

  always_comb begin
    mul_req.start = start_i | (mul_done & ~phase_q);
    if (start_i) begin
      mul_req.a = value_i ^ (value_i >> 33);
      mul_req.b = FMIX_F1;
    end else begin
      mul_req.a = res_xs;
      mul_req.b = FMIX_F2;
    end
  end

  mh3_mul64 u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mul_req),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= mul_done & phase_q;
      if (start_i) begin
        phase_q <= 1'b0;
      end else if (mul_done && !phase_q) begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_done && phase_q) begin
      result_q <= res_xs;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== hw/rtl/murmur3_x64_128_hash_unit.sv =====
// MurmurHash3 x64_128 (seed zero), 16-byte blocks; depends on mh3_pkg, mh3_lane, mh3_fmix.
// A non-final block occupies the unit through the two chained 64-bit multiplies in each
//   key lane plus four hash-word mixing steps; no new block is taken before it is done.
// A final block then adds length xor, pre-adds, finalizers and a post-add (none if empty).
// A finished result waits in the output register while the next block is taken in.
// Reset (rst_ni low, asynchronous) clears the hash words, byte length and sequencer.
module murmur3_x64_128_hash_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] block_lo_i,
  input  logic [63:0] block_hi_i,
  input  logic [4:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_lo_o,
  output logic [63:0] hash_hi_o,
  output logic        hash_valid_o
);
  import mh3_pkg::*;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_LANE      = 4'd1;
  localparam logic [3:0] ST_MIX1      = 4'd2;
  localparam logic [3:0] ST_MIX2      = 4'd3;
  localparam logic [3:0] ST_MIX3      = 4'd4;
  localparam logic [3:0] ST_MIX4      = 4'd5;
  localparam logic [3:0] ST_TAIL      = 4'd6;
  localparam logic [3:0] ST_CHECK     = 4'd7;
  localparam logic [3:0] ST_PRE1      = 4'd8;
  localparam logic [3:0] ST_PRE2      = 4'd9;
  localparam logic [3:0] ST_FMIX_GO   = 4'd10;
  localparam logic [3:0] ST_FMIX_WAIT = 4'd11;
  localparam logic [3:0] ST_POST1     = 4'd12;
  localparam logic [3:0] ST_OUT       = 4'd13;

  logic [3:0]  st_q, st_d;
  logic [63:0] m1_q, m1_d, m2_q, m2_d, tot_q, tot_d;
  logic        last_q, last_d, full_q, full_d, empty_q, empty_d;
  logic        out_valid_q, out_valid_d;
  logic        out_load;
  logic [63:0] hash_lo_q, hash_lo_d, hash_hi_q, hash_hi_d;
  logic        hash_valid_q, hash_valid_d;

  logic        in_accept;
  logic [4:0]  cnt_clamp, eff_cnt;
  logic [3:0]  lo_bytes, hi_bytes;
  logic [63:0] key_lo, key_hi;
  logic        k1_done, k2_done, f1_done, f2_done, fmix_start;
  logic [63:0] k1, k2, f1, f2;

  assign in_stall_o = (st_q != ST_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;

  // Byte count: clamp to a block, non-final blocks are always full
  assign cnt_clamp = (byte_count_i > BLOCK_BYTES) ? BLOCK_BYTES : byte_count_i;
  assign eff_cnt   = last_i ? cnt_clamp : BLOCK_BYTES;
  assign lo_bytes  = (eff_cnt >= LANE_BYTES) ? 4'd8 : eff_cnt[3:0];
  assign hi_bytes  = (eff_cnt > LANE_BYTES) ? 4'(eff_cnt - LANE_BYTES) : 4'd0;
  assign key_lo    = block_lo_i & byte_mask(lo_bytes);
  assign key_hi    = block_hi_i & byte_mask(hi_bytes);

  // Key lanes; a masked-out lane yields zero, so the tail xor is harmless
  mh3_lane u_lane_one (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .lane_two_i (1'b0),
    .key_i      (key_lo),
    .done_o     (k1_done),
    .result_o   (k1)
  );

  mh3_lane u_lane_two (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .lane_two_i (1'b1),
    .key_i      (key_hi),
    .done_o     (k2_done),
    .result_o   (k2)
  );

  // Finalizers, one per hash word
  mh3_fmix u_fmix_one (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (fmix_start),
    .value_i  (m1_q),
    .done_o   (f1_done),
    .result_o (f1)
  );

  mh3_fmix u_fmix_two (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (fmix_start),
    .value_i  (m2_q),
    .done_o   (f2_done),
    .result_o (f2)
  );

  // Merge sequencer: folds lane keys into the hash words, and finalizes after the last block
  always_comb begin
    st_d         = st_q;
    m1_d         = m1_q;
    m2_d         = m2_q;
    tot_d        = tot_q;
    last_d       = last_q;
    full_d       = full_q;
    empty_d      = empty_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_load     = 1'b0;
    hash_lo_d    = m1_q;
    hash_hi_d    = m1_q + m2_q;
    hash_valid_d = 1'b1;
    fmix_start   = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (in_accept) begin
          tot_d  = tot_q + {59'd0, eff_cnt};
          last_d = last_i;
          full_d = (eff_cnt == BLOCK_BYTES);
          st_d   = ST_LANE;
        end
      end
      ST_LANE: begin
        if (k1_done && k2_done) begin
          st_d = full_q ? ST_MIX1 : ST_TAIL;
        end
      end
      ST_MIX1: begin
        m1_d = {(m1_q[36:0] ^ k1[36:0]), (m1_q[63:37] ^ k1[63:37])} + m2_q;
        st_d = ST_MIX2;
      end
      ST_MIX2: begin
        m1_d = {m1_q[61:0], 2'b00} + m1_q + MIX_ADD1;
        st_d = ST_MIX3;
      end
      ST_MIX3: begin
        m2_d = {(m2_q[32:0] ^ k2[32:0]), (m2_q[63:33] ^ k2[63:33])} + m1_q;
        st_d = ST_MIX4;
      end
      ST_MIX4: begin
        m2_d = {m2_q[61:0], 2'b00} + m2_q + MIX_ADD2;
        st_d = last_q ? ST_CHECK : ST_IDLE;
      end
      ST_TAIL: begin
        m1_d = m1_q ^ k1;
        m2_d = m2_q ^ k2;
        st_d = ST_CHECK;
      end
      ST_CHECK: begin
        // zero length (empty or wrapped) gives an all-zero, not-valid hash
        if (tot_q == 64'd0) begin
          empty_d = 1'b1;
          st_d    = ST_OUT;
        end else begin
          m1_d = m1_q ^ tot_q;
          m2_d = m2_q ^ tot_q;
          st_d = ST_PRE1;
        end
      end
      ST_PRE1: begin
        m1_d = m1_q + m2_q;
        st_d = ST_PRE2;
      end
      ST_PRE2: begin
        m2_d = m2_q + m1_q;
        st_d = ST_FMIX_GO;
      end
      ST_FMIX_GO: begin
        fmix_start = 1'b1;
        st_d       = ST_FMIX_WAIT;
      end
      ST_FMIX_WAIT: begin
        if (f1_done && f2_done) begin
          m1_d = f1;
          m2_d = f2;
          st_d = ST_POST1;
        end
      end
      ST_POST1: begin
        m1_d = m1_q + m2_q;
        st_d = ST_OUT;
      end
      ST_OUT: begin
        // write the result once the output register is free, then clear state
        if (!out_valid_q || !out_stall_i) begin
          out_load     = 1'b1;
          out_valid_d  = 1'b1;
          hash_valid_d = ~empty_q;
          if (empty_q) begin
            hash_lo_d = 64'd0;
            hash_hi_d = 64'd0;
          end
          m1_d    = 64'd0;
          m2_d    = 64'd0;
          tot_d   = 64'd0;
          empty_d = 1'b0;
          st_d    = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      m1_q        <= 64'd0;
      m2_q        <= 64'd0;
      tot_q       <= 64'd0;
      last_q      <= 1'b0;
      full_q      <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      m1_q        <= m1_d;
      m2_q        <= m2_d;
      tot_q       <= tot_d;
      last_q      <= last_d;
      full_q      <= full_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload, loaded on each result write
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      hash_lo_q    <= hash_lo_d;
      hash_hi_q    <= hash_hi_d;
      hash_valid_q <= hash_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_lo_o    = hash_lo_q;
  assign hash_hi_o    = hash_hi_q;
  assign hash_valid_o = hash_valid_q;

endmodule

// ===== hw/rtl/mh3_port_checker.sv =====
// mh3_port_checker: port-level assertions for murmur3_x64_128_hash_unit.
// Sees only the top-level ports; attached by the bind statement below.
module mh3_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] hash_lo_o,
  input logic [63:0] hash_hi_o,
  input logic        hash_valid_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(hash_lo_o) && $stable(hash_hi_o) && $stable(hash_valid_o))
    else $error("result payload changed while stalled");

  // An empty-message result carries a zero hash
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hash_valid_o |-> hash_lo_o == 64'd0 && hash_hi_o == 64'd0)
    else $error("empty message with nonzero hash");

  // Each block transfer occupies the unit for at least the next cycle
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken back to back");

  // A new result is written only from a busy unit
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in flight");

endmodule

bind murmur3_x64_128_hash_unit mh3_port_checker u_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .hash_lo_o    (hash_lo_o),
  .hash_hi_o    (hash_hi_o),
  .hash_valid_o (hash_valid_o)
);
